// ----- sv/mktd_pkg.sv -----
// ----------------------------------------------------------------------------
// Morse key timing decoder package
// Shared types, register indexes, reset values and the Morse code table.
// ----------------------------------------------------------------------------
package mktd_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int SCALED_W    = 23;
	localparam int MS_SCALE    = 125;
	localparam int SYM_LIMIT   = 8;
	localparam int CHAR_W      = 7;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_DOT_MIN   = 3'd0,
		CFG_DASH_MIN  = 3'd1,
		CFG_DASH_MAX  = 3'd2,
		CFG_SPACE_MIN = 3'd3,
		CFG_SPACE_MAX = 3'd4
	} cfg_index_t;

	typedef enum logic [1:0] {
		SYM_DOT    = 2'd0,
		SYM_DASH   = 2'd1,
		SYM_REJECT = 2'd2
	} symbol_class_t;

	typedef enum logic {
		KIND_SYMBOL = 1'b0,
		KIND_CHAR   = 1'b1
	} result_kind_t;

	localparam logic [CFG_DATA_W-1:0] DOT_MIN_RST   = 16'd30;
	localparam logic [CFG_DATA_W-1:0] DASH_MIN_RST  = 16'd200;
	localparam logic [CFG_DATA_W-1:0] DASH_MAX_RST  = 16'd1000;
	localparam logic [CFG_DATA_W-1:0] SPACE_MIN_RST = 16'd1000;
	localparam logic [CFG_DATA_W-1:0] SPACE_MAX_RST = 16'd42000;

	localparam logic [CHAR_W-1:0] CHAR_UNKNOWN = 7'h3F;

	// Thresholds in units of 2*ticks, so that a tick count is compared without a divide.
	typedef struct packed {
		logic [SCALED_W-1:0] dot_lo;
		logic [SCALED_W-1:0] dash_lo;
		logic [SCALED_W-1:0] dash_hi;
		logic [SCALED_W-1:0] space_lo;
		logic [SCALED_W-1:0] space_hi;
	} limits_t;

	// The buffer holds the first symbol in bit 0, with a dash as 1.
	function automatic logic [CHAR_W-1:0] decode_char(input logic ovf, input logic [3:0] count,
			input logic [SYM_LIMIT-1:0] bits);
		logic [CHAR_W-1:0] ch;
		ch = CHAR_UNKNOWN;
		if (!ovf && count <= 4'd5 && bits[7:5] == 3'b000) begin
			case ({count[2:0], bits[4:0]})
				{3'd2, 5'b00010}: ch = 7'h41;
				{3'd4, 5'b00001}: ch = 7'h42;
				{3'd4, 5'b00101}: ch = 7'h43;
				{3'd3, 5'b00001}: ch = 7'h44;
				{3'd1, 5'b00000}: ch = 7'h45;
				{3'd4, 5'b00100}: ch = 7'h46;
				{3'd3, 5'b00011}: ch = 7'h47;
				{3'd4, 5'b00000}: ch = 7'h48;
				{3'd2, 5'b00000}: ch = 7'h49;
				{3'd4, 5'b01110}: ch = 7'h4A;
				{3'd3, 5'b00101}: ch = 7'h4B;
				{3'd4, 5'b00010}: ch = 7'h4C;
				{3'd2, 5'b00011}: ch = 7'h4D;
				{3'd2, 5'b00001}: ch = 7'h4E;
				{3'd3, 5'b00111}: ch = 7'h4F;
				{3'd4, 5'b00110}: ch = 7'h50;
				{3'd4, 5'b01011}: ch = 7'h51;
				{3'd3, 5'b00010}: ch = 7'h52;
				{3'd3, 5'b00000}: ch = 7'h53;
				{3'd1, 5'b00001}: ch = 7'h54;
				{3'd3, 5'b00100}: ch = 7'h55;
				{3'd4, 5'b01000}: ch = 7'h56;
				{3'd3, 5'b00110}: ch = 7'h57;
				{3'd4, 5'b01001}: ch = 7'h58;
				{3'd4, 5'b01101}: ch = 7'h59;
				{3'd4, 5'b00011}: ch = 7'h5A;
				{3'd5, 5'b11110}: ch = 7'h31;
				{3'd5, 5'b11100}: ch = 7'h32;
				{3'd5, 5'b11000}: ch = 7'h33;
				{3'd5, 5'b10000}: ch = 7'h34;
				{3'd5, 5'b00000}: ch = 7'h35;
				{3'd5, 5'b00001}: ch = 7'h36;
				{3'd5, 5'b00011}: ch = 7'h37;
				{3'd5, 5'b00111}: ch = 7'h38;
				{3'd5, 5'b01111}: ch = 7'h39;
				{3'd5, 5'b11111}: ch = 7'h30;
				default: ch = CHAR_UNKNOWN;
			endcase
		end
		return ch;
	endfunction

endpackage

// ----- sv/mktd_cfg.sv -----
// ----------------------------------------------------------------------------
// Morse key timing decoder threshold registers
// Takes register writes and keeps each threshold prescaled to 2*ticks units.
// ----------------------------------------------------------------------------
module mktd_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [mktd_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [mktd_pkg::CFG_DATA_W-1:0]      cfg_data,
	output mktd_pkg::limits_t                    limits
);

	// A strict lower bound on milliseconds becomes an inclusive bound one step higher.
	function automatic logic [mktd_pkg::SCALED_W-1:0] scale(
			input logic [mktd_pkg::CFG_DATA_W-1:0] value, input logic plus_one);
		logic [mktd_pkg::SCALED_W-1:0] base;
		base = mktd_pkg::SCALED_W'(value) + mktd_pkg::SCALED_W'(plus_one);
		return mktd_pkg::SCALED_W'(base * mktd_pkg::SCALED_W'(mktd_pkg::MS_SCALE));
	endfunction

	mktd_pkg::limits_t limits_q;

	assign cfg_ready = 1'b1;
	assign limits    = limits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.dot_lo   <= scale(mktd_pkg::DOT_MIN_RST, 1'b1);
			limits_q.dash_lo  <= scale(mktd_pkg::DASH_MIN_RST, 1'b0);
			limits_q.dash_hi  <= scale(mktd_pkg::DASH_MAX_RST, 1'b0);
			limits_q.space_lo <= scale(mktd_pkg::SPACE_MIN_RST, 1'b1);
			limits_q.space_hi <= scale(mktd_pkg::SPACE_MAX_RST, 1'b0);
		end else if (cfg_valid) begin
			case (cfg_index)
				mktd_pkg::CFG_DOT_MIN:   limits_q.dot_lo   <= scale(cfg_data, 1'b1);
				mktd_pkg::CFG_DASH_MIN:  limits_q.dash_lo  <= scale(cfg_data, 1'b0);
				mktd_pkg::CFG_DASH_MAX:  limits_q.dash_hi  <= scale(cfg_data, 1'b0);
				mktd_pkg::CFG_SPACE_MIN: limits_q.space_lo <= scale(cfg_data, 1'b1);
				mktd_pkg::CFG_SPACE_MAX: limits_q.space_hi <= scale(cfg_data, 1'b0);
				default: ;
			endcase
		end
	end

endmodule

// ----- sv/mktd_front.sv -----
// ----------------------------------------------------------------------------
// Morse key timing decoder front end
// Accepts key edges, keeps the last press and release times and measures
// the elapsed ticks for each edge.
// ----------------------------------------------------------------------------
module mktd_front #(
	parameter int TIME_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  level,
	input  logic [TIME_WIDTH-1:0] timestamp,
	output logic                  push_valid,
	input  logic                  push_ready,
	output logic [TIME_WIDTH:0]   push_data
);

	logic [TIME_WIDTH-1:0] press_time_q;
	logic [TIME_WIDTH-1:0] release_time_q;
	logic [TIME_WIDTH-1:0] delta;
	logic                  take;

	assign in_ready   = push_ready;
	assign push_valid = in_valid;
	assign take       = in_valid && push_ready;
	assign delta      = timestamp - (level ? release_time_q : press_time_q);
	assign push_data  = {level, delta};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_time_q   <= '0;
			release_time_q <= '0;
		end else if (take) begin
			if (level) begin
				press_time_q <= timestamp;
			end else begin
				release_time_q <= timestamp;
			end
		end
	end

endmodule

// ----- sv/mktd_queue.sv -----
// ----------------------------------------------------------------------------
// Morse key timing decoder queue
// Small FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module mktd_queue #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (cnt_q != CNT_W'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
		return (ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(ptr + 1'b1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- sv/mktd_back.sv -----
// ----------------------------------------------------------------------------
// Morse key timing decoder back end
// Classifies presses and gaps, keeps the symbol buffer, decodes characters
// and holds the result in an output register.
// ----------------------------------------------------------------------------
module mktd_back #(
	parameter int TIME_WIDTH  = 32,
	parameter int MAX_SYMBOLS = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pop_valid,
	output logic                          pop_ready,
	input  logic [TIME_WIDTH:0]           pop_data,
	input  mktd_pkg::limits_t             limits,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic                          res_kind,
	output logic [1:0]                    res_class,
	output logic [mktd_pkg::CHAR_W-1:0]   res_char
);

	localparam int CMP_W = (TIME_WIDTH + 1 > mktd_pkg::SCALED_W) ? TIME_WIDTH + 1
		: mktd_pkg::SCALED_W;
	localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
	localparam int IDX_W = $clog2(MAX_SYMBOLS);

	logic [MAX_SYMBOLS-1:0]        bits_q;
	logic [CNT_W-1:0]              count_q;
	logic                          ovf_q;
	logic [MAX_SYMBOLS-1:0]        bits_d;
	logic [CNT_W-1:0]              count_d;
	logic                          ovf_d;
	logic                          out_valid_q;
	logic                          out_kind_q;
	logic [1:0]                    out_class_q;
	logic [mktd_pkg::CHAR_W-1:0]   out_char_q;

	logic                          level;
	logic [CMP_W-1:0]              twice;
	logic                          is_space;
	logic                          take;
	logic                          emit;
	mktd_pkg::symbol_class_t       cls;
	logic [mktd_pkg::CHAR_W-1:0]   ch;

	assign level     = pop_data[TIME_WIDTH];
	assign twice     = CMP_W'({pop_data[TIME_WIDTH-1:0], 1'b0});
	assign pop_ready = !out_valid_q || res_ready;
	assign take      = pop_valid && pop_ready;
	assign is_space  = (twice >= CMP_W'(limits.space_lo)) && (twice < CMP_W'(limits.space_hi));
	assign emit      = take && (!level || is_space);
	assign ch        = mktd_pkg::decode_char(ovf_q, 4'(count_q),
		mktd_pkg::SYM_LIMIT'(bits_q));

	always_comb begin
		cls = mktd_pkg::SYM_REJECT;
		if (twice >= CMP_W'(limits.dot_lo) && twice < CMP_W'(limits.dash_lo)) begin
			cls = mktd_pkg::SYM_DOT;
		end else if (twice >= CMP_W'(limits.dash_lo) && twice < CMP_W'(limits.dash_hi)) begin
			cls = mktd_pkg::SYM_DASH;
		end
	end

	always_comb begin
		bits_d  = bits_q;
		count_d = count_q;
		ovf_d   = ovf_q;
		if (take) begin
			if (!level) begin
				if (cls != mktd_pkg::SYM_REJECT) begin
					if (count_q == CNT_W'(MAX_SYMBOLS)) begin
						ovf_d = 1'b1;
					end else begin
						bits_d[count_q[IDX_W-1:0]] = (cls == mktd_pkg::SYM_DASH);
						count_d = count_q + 1'b1;
					end
				end
			end else if (is_space) begin
				bits_d  = '0;
				count_d = '0;
				ovf_d   = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q      <= '0;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			bits_q  <= bits_d;
			count_q <= count_d;
			ovf_q   <= ovf_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (level) begin
				out_kind_q  <= mktd_pkg::KIND_CHAR;
				out_class_q <= '0;
				out_char_q  <= ch;
			end else begin
				out_kind_q  <= mktd_pkg::KIND_SYMBOL;
				out_class_q <= cls;
				out_char_q  <= '0;
			end
		end
	end

	assign res_valid = out_valid_q;
	assign res_kind  = out_kind_q;
	assign res_class = out_class_q;
	assign res_char  = out_char_q;

endmodule

// ----- sv/morse_key_timing_decoder_unit.sv -----
// A result is registered: it passes the queue and then the output register of the back end.
// One key edge per cycle is accepted while m_tready does not hold off the result stream.
// A release always gives one result; a press gives one only when its gap ends a character.
// Reset restores the default thresholds and clears the timestamps and the symbol buffer.
// ----------------------------------------------------------------------------
// Morse key timing decoder
// Turns timestamped key edges into dot, dash and reject classes and decoded characters.
// ----------------------------------------------------------------------------
module morse_key_timing_decoder_unit #(
	parameter int TIME_WIDTH  = 32,
	parameter int MAX_SYMBOLS = 5,
	localparam int S_TDATA_W  = ((TIME_WIDTH + 7) / 8) * 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [S_TDATA_W-1:0]              s_tdata,   // timestamp
	input  logic                              s_tuser,   // edge_level
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [15:0]                       m_tdata,   // symbol_class, character
	output logic                              m_tuser,   // result_kind
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mktd_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [mktd_pkg::CFG_DATA_W-1:0]   cfg_data
);

	mktd_pkg::limits_t            limits;
	logic                         push_valid;
	logic                         push_ready;
	logic [TIME_WIDTH:0]          push_data;
	logic                         pop_valid;
	logic                         pop_ready;
	logic [TIME_WIDTH:0]          pop_data;
	logic [1:0]                   res_class;
	logic [mktd_pkg::CHAR_W-1:0]  res_char;

	mktd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.limits    (limits)
	);

	mktd_front #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.level      (s_tuser),
		.timestamp  (s_tdata[TIME_WIDTH-1:0]),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	mktd_queue #(
		.WIDTH (TIME_WIDTH + 1),
		.DEPTH (2)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	mktd_back #(
		.TIME_WIDTH  (TIME_WIDTH),
		.MAX_SYMBOLS (MAX_SYMBOLS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.limits    (limits),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res_kind  (m_tuser),
		.res_class (res_class),
		.res_char  (res_char)
	);

	assign m_tdata = {7'b0, res_char, res_class};

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// Morse key timing decoder testbench
// Sends timestamped key edges over the input stream and checks each symbol
// class and decoded character against a predictor of the timing rules. A
// directed table comes first. Random characters, mostly well formed, follow
// under several threshold settings, with random idling on both streams and
// one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import mktd_pkg::*;

	localparam int MARK_LIMIT      = 5;
	localparam int HOLD_OFF_CYCLES = 200;

	typedef struct packed {
		result_kind_t      kind;
		symbol_class_t     cls;
		logic [CHAR_W-1:0] ch;
	} key_result_t;

	typedef enum logic [1:0] {
		CHK_MODEL,
		CHK_NONE,
		CHK_GIVEN
	} row_check_t;

	typedef struct {
		logic        lvl;
		bit          absolute;
		logic [31:0] val;
		row_check_t  chk;
		key_result_t given;
	} edge_row_t;

	localparam key_result_t BLANK = '{KIND_SYMBOL, SYM_DOT, '0};

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [31:0]            s_tdata = '0;
	logic                   s_tuser = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [15:0]            m_tdata;
	logic                   m_tuser;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	logic [CFG_DATA_W-1:0] thr [5] = '{DOT_MIN_RST, DASH_MIN_RST, DASH_MAX_RST,
		SPACE_MIN_RST, SPACE_MAX_RST};
	logic [31:0] key_down_ts = '0;
	logic [31:0] key_up_ts = '0;
	string       mark_buf = "";
	bit          mark_overflow = 1'b0;

	key_result_t pending [$];
	int          errors = 0;
	bit          idle_on = 1'b1;
	bit          hold_request = 1'b0;

	string morse_list [36] = '{
		"A.-", "B-...", "C-.-.", "D-..", "E.", "F..-.", "G--.", "H....", "I..",
		"J.---", "K-.-", "L.-..", "M--", "N-.", "O---", "P.--.", "Q--.-", "R.-.",
		"S...", "T-", "U..-", "V...-", "W.--", "X-..-", "Y-.--", "Z--..",
		"1.----", "2..---", "3...--", "4....-", "5.....", "6-....", "7--...",
		"8---..", "9----.", "0-----"};

	logic [CFG_DATA_W-1:0] phase_set [1:6][5] = '{
		'{16'd30, 16'd200, 16'd1000, 16'd1000, 16'd42000},
		'{16'd5, 16'd20, 16'd60, 16'd80, 16'd400},
		'{16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
		'{16'd0, 16'd1, 16'd65535, 16'd0, 16'd65535},
		'{16'd10, 16'd300, 16'd200, 16'd100, 16'd5000},
		'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}};
	int phase_items [1:6] = '{110, 80, 30, 80, 80, 40};

	morse_key_timing_decoder_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic logic [31:0] ms_to_ticks(input int unsigned ms, input bit jitter);
		logic [63:0] ticks;
		ticks = (64'(ms) * 125 + 1) / 2;
		if (jitter) begin
			ticks = ticks + $urandom_range(0, 61);
		end
		return ticks[31:0];
	endfunction

	// A release classifies the press; a press ends a character when its gap
	// falls inside the space window.
	function automatic bit predict_edge(input logic lvl, input logic [31:0] ts,
			output key_result_t res);
		logic [31:0] span;
		logic [63:0] ms;
		byte         letter;
		res = BLANK;
		if (!lvl) begin
			span = ts - key_down_ts;
			ms = {32'd0, span} * 2 / 125;
			key_up_ts = ts;
			if (ms > thr[CFG_DOT_MIN] && ms < thr[CFG_DASH_MIN]) begin
				res.cls = SYM_DOT;
			end else if (ms >= thr[CFG_DASH_MIN] && ms < thr[CFG_DASH_MAX]) begin
				res.cls = SYM_DASH;
			end else begin
				res.cls = SYM_REJECT;
			end
			if (res.cls != SYM_REJECT) begin
				if (mark_buf.len() >= MARK_LIMIT) begin
					mark_overflow = 1'b1;
				end else if (res.cls == SYM_DASH) begin
					mark_buf = {mark_buf, "-"};
				end else begin
					mark_buf = {mark_buf, "."};
				end
			end
			return 1'b1;
		end
		span = ts - key_up_ts;
		ms = {32'd0, span} * 2 / 125;
		key_down_ts = ts;
		if (!(ms > thr[CFG_SPACE_MIN] && ms < thr[CFG_SPACE_MAX])) begin
			return 1'b0;
		end
		res.kind = KIND_CHAR;
		res.ch = CHAR_UNKNOWN;
		if (!mark_overflow) begin
			foreach (morse_list[e]) begin
				if (morse_list[e].substr(1, morse_list[e].len() - 1) == mark_buf) begin
					letter = morse_list[e].getc(0);
					res.ch = letter[CHAR_W-1:0];
				end
			end
		end
		mark_buf = "";
		mark_overflow = 1'b0;
		return 1'b1;
	endfunction

	function automatic int unsigned pick_hold_ms();
		int unsigned dot_lo = thr[CFG_DOT_MIN];
		int unsigned dash_lo = thr[CFG_DASH_MIN];
		int unsigned dash_hi = thr[CFG_DASH_MAX];
		case ($urandom_range(0, 11))
			0: return dot_lo;
			1: return dot_lo + 1;
			2: return (dash_lo == 0) ? 0 : dash_lo - 1;
			3: return dash_lo;
			4: return (dash_hi == 0) ? 0 : dash_hi - 1;
			5: return dash_hi;
			6, 7, 8: begin
				if (dot_lo + 1 < dash_lo) begin
					return $urandom_range(dot_lo + 1, dash_lo - 1);
				end
				return $urandom_range(0, 2000);
			end
			9, 10: begin
				if (dash_lo < dash_hi) begin
					return $urandom_range(dash_lo, dash_hi - 1);
				end
				return $urandom_range(0, 2000);
			end
			default: return $urandom_range(0, 70000);
		endcase
	endfunction

	function automatic int unsigned pick_gap_ms(input bit ending);
		int unsigned lo = thr[CFG_SPACE_MIN];
		int unsigned hi = thr[CFG_SPACE_MAX];
		int unsigned r = $urandom_range(0, 19);
		if (!ending && r < 17) begin
			return $urandom_range(0, lo);
		end
		if (ending && r < 14 && lo + 1 < hi) begin
			return $urandom_range(lo + 1, hi - 1);
		end
		case (r % 4)
			0: return lo;
			1: return lo + 1;
			2: return (hi == 0) ? 0 : hi - 1;
			default: return $urandom_range(0, 70000);
		endcase
	endfunction

	task automatic send_edge(input logic lvl, input logic [31:0] ts, input row_check_t chk,
			input key_result_t given);
		key_result_t res;
		bit          got;
		while (idle_on && $urandom_range(0, 99) < 15) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= lvl;
		s_tdata <= ts;
		do @(posedge clk); while (!s_tready);
		got = predict_edge(lvl, ts, res);
		if (chk == CHK_GIVEN) begin
			pending.push_back(given);
		end else if (chk == CHK_MODEL && got) begin
			pending.push_back(res);
		end
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		thr[idx] = value;
	endtask

	// Mostly whole characters of one to five symbols, now and then an overlong
	// one, with stray edges mixed in.
	task automatic random_phase(input int target);
		int          sent;
		int          marks;
		int          k;
		logic [31:0] ts;
		sent = 0;
		ts = $urandom;
		while (sent < target) begin
			marks = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 7) : $urandom_range(1, 5);
			for (k = 0; k < marks; k++) begin
				if ($urandom_range(0, 19) == 0) begin
					ts = $urandom_range(0, 1) ? $urandom : ts + $urandom_range(0, 200000);
					send_edge($urandom_range(0, 1), ts, CHK_MODEL, BLANK);
					sent++;
				end
				ts = ts + ms_to_ticks(pick_gap_ms(k == 0), 1'b1);
				send_edge(1'b1, ts, CHK_MODEL, BLANK);
				ts = ts + ms_to_ticks(pick_hold_ms(), 1'b1);
				send_edge(1'b0, ts, CHK_MODEL, BLANK);
				sent += 2;
			end
		end
	endtask

	always @(posedge clk) begin : result_check
		key_result_t want;
		if (m_tvalid && m_tready) begin
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, got tuser %0d tdata %h",
					$time, m_tuser, m_tdata);
			end else begin
				want = pending.pop_front();
				if (m_tuser !== want.kind) begin
					errors++;
					$display("%0t: result_kind expected %0d got %0d", $time, want.kind,
						m_tuser);
				end
				if (m_tdata[1:0] !== want.cls) begin
					errors++;
					$display("%0t: symbol_class expected %0d got %0d", $time, want.cls,
						m_tdata[1:0]);
				end
				if (m_tdata[8:2] !== want.ch) begin
					errors++;
					$display("%0t: character expected %h got %h", $time, want.ch,
						m_tdata[8:2]);
				end
				if (m_tdata[15:9] !== '0) begin
					errors++;
					$display("%0t: tdata padding expected 0 got %h", $time, m_tdata[15:9]);
				end
			end
		end
	end

	initial begin : ready_drive
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= !(idle_on && $urandom_range(0, 99) < 15);
			end
		end
	end

	initial begin
		#3_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : main_flow
		edge_row_t   rows [$];
		logic [31:0] cur;
		cfg_index_t  idx;
		int          p;
		cur = '0;

		// Timing boundaries under the reset thresholds, repeated levels, a full
		// buffer and a timestamp wrap.
		rows.push_back('{1'b0, 1'b1, 32'd0, CHK_GIVEN, '{KIND_SYMBOL, SYM_REJECT, '0}});
		rows.push_back('{1'b1, 1'b0, 32'd0, CHK_NONE, BLANK});
		rows.push_back('{1'b1, 1'b0, ms_to_ticks(2000, 0), CHK_GIVEN,
			'{KIND_CHAR, SYM_DOT, CHAR_UNKNOWN}});
		rows.push_back('{1'b0, 1'b0, ms_to_ticks(30, 0), CHK_GIVEN,
			'{KIND_SYMBOL, SYM_REJECT, '0}});
		rows.push_back('{1'b1, 1'b0, ms_to_ticks(1000, 0), CHK_NONE, BLANK});
		rows.push_back('{1'b0, 1'b0, ms_to_ticks(31, 0), CHK_MODEL, BLANK});
		rows.push_back('{1'b1, 1'b0, ms_to_ticks(50, 0), CHK_MODEL, BLANK});
		rows.push_back('{1'b0, 1'b0, ms_to_ticks(199, 0), CHK_MODEL, BLANK});
		rows.push_back('{1'b1, 1'b0, ms_to_ticks(50, 0), CHK_MODEL, BLANK});
		rows.push_back('{1'b0, 1'b0, ms_to_ticks(200, 0), CHK_MODEL, BLANK});
		rows.push_back('{1'b1, 1'b0, ms_to_ticks(50, 0), CHK_MODEL, BLANK});
		rows.push_back('{1'b0, 1'b0, ms_to_ticks(999, 0), CHK_MODEL, BLANK});
		rows.push_back('{1'b0, 1'b0, ms_to_ticks(1000, 0), CHK_GIVEN,
			'{KIND_SYMBOL, SYM_REJECT, '0}});
		rows.push_back('{1'b1, 1'b0, ms_to_ticks(50, 0), CHK_MODEL, BLANK});
		rows.push_back('{1'b0, 1'b0, ms_to_ticks(100, 0), CHK_MODEL, BLANK});
		rows.push_back('{1'b1, 1'b0, ms_to_ticks(50, 0), CHK_MODEL, BLANK});
		rows.push_back('{1'b0, 1'b0, ms_to_ticks(100, 0), CHK_MODEL, BLANK});
		rows.push_back('{1'b1, 1'b0, ms_to_ticks(42000, 0), CHK_NONE, BLANK});
		rows.push_back('{1'b0, 1'b1, 32'hFFFF_FFFF, CHK_MODEL, BLANK});
		rows.push_back('{1'b1, 1'b0, ms_to_ticks(41999, 0), CHK_GIVEN,
			'{KIND_CHAR, SYM_DOT, CHAR_UNKNOWN}});
		rows.push_back('{1'b0, 1'b0, ms_to_ticks(150, 0), CHK_MODEL, BLANK});
		rows.push_back('{1'b1, 1'b0, 32'hFFFF_FFFF, CHK_NONE, BLANK});
		rows.push_back('{1'b0, 1'b0, ms_to_ticks(150, 0), CHK_MODEL, BLANK});
		rows.push_back('{1'b1, 1'b0, ms_to_ticks(1001, 0), CHK_MODEL, BLANK});

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			cur = rows[i].absolute ? rows[i].val : cur + rows[i].val;
			send_edge(rows[i].lvl, cur, rows[i].chk, rows[i].given);
		end
		s_tvalid <= 1'b0;

		for (p = 1; p <= 6; p++) begin
			while (pending.size() != 0) @(posedge clk);
			repeat (4) @(posedge clk);
			idle_on = (p != 2);
			idx = idx.first();
			repeat (5) begin
				write_reg(idx, phase_set[p][int'(idx)]);
				idx = idx.next();
			end
			cfg_valid <= 1'b0;
			if (p == 1) begin
				hold_request = 1'b1;
			end
			random_phase(phase_items[p]);
			s_tvalid <= 1'b0;
		end

		while (pending.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ----- files.f -----
sv/mktd_pkg.sv
sv/mktd_cfg.sv
sv/mktd_front.sv
sv/mktd_queue.sv
sv/mktd_back.sv
sv/morse_key_timing_decoder_unit.sv
tb/testbench.sv
